// File: rtl/swpr_pkg.sv
package swpr_pkg;

	localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
	localparam int unsigned CLASS_DIV = 100;
	localparam int unsigned ERR_CLASS = 5;
	localparam logic [9:0]  ERR_LO    = 10'(ERR_CLASS * CLASS_DIV);
	localparam logic [9:0]  ERR_HI    = 10'((ERR_CLASS + 1) * CLASS_DIV);

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_PREP    = 8'b0000_0100,
		ST_ADV_RD  = 8'b0000_1000,
		ST_ADV_WR  = 8'b0001_0000,
		ST_HEAD_RD = 8'b0010_0000,
		ST_HEAD_WR = 8'b0100_0000,
		ST_OUT     = 8'b1000_0000
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == SAT32) ? v : v + 32'd1;
	endfunction

endpackage

// File: rtl/swpr_if.sv
interface swpr_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] event_time;
	logic [9:0]  status_code;

	modport source (output valid, output event_time, output status_code, input ready);
	modport sink   (input valid, input event_time, input status_code, output ready);
endinterface

interface swpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] peak_count;
	logic [31:0] peak_window_end;
	logic [31:0] server_error_total;
	logic        is_server_error;

	modport source (output valid, output peak_count, output peak_window_end,
		output server_error_total, output is_server_error, input ready);
	modport sink   (input valid, input peak_count, input peak_window_end,
		input server_error_total, input is_server_error, output ready);
endinterface

// File: rtl/sliding_window_peak_rate_core.sv
// Sliding-window peak request rate counter.
// req: one request per handshake (event_time in seconds, status_code).
// rsp: one result per request: peak window count, end second of that
//   window, running 5xx total and the 5xx flag of this request.
// cfg: cfg_we/cfg_wdata write the window length in seconds (0 acts as 1,
//   above MAX_WINDOW acts as MAX_WINDOW). A write clears the bucket ring.
// Per-second counts live in a RAM of MAX_WINDOW words with one read and
// one write port; one sequencer reads, retires and updates them one bucket
// at a time. An accepted request runs PREP, then an ADV_RD/ADV_WR pair
// per retired bucket (min(time step, window) of them, none if the second
// does not advance), then HEAD_RD, HEAD_WR and OUT into the result register;
// each retired bucket costs one RAM read and one write. req.ready is high
// only while the sequencer is idle. After reset and after each cfg write a
// clearing pass runs over the RAM, during which no request is accepted.
// The result sits in an output register; the next request is accepted
// while it waits, and its result is held back until rsp.ready takes the
// previous one.
module sliding_window_peak_rate_core #(
	parameter int MAX_WINDOW = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [12:0]       cfg_wdata,
	swpr_req_if.sink          req,
	swpr_rsp_if.source        rsp
);
	import swpr_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WW = $clog2(MAX_WINDOW + 1);

	state_t          state_q;
	logic [12:0]     win_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   leave_q;
	logic [WW-1:0]   steps_q;
	logic [31:0]     sum_q;
	logic [31:0]     last_q;
	logic            seen_q;
	logic [31:0]     best_q;
	logic [31:0]     best_end_q;
	logic [31:0]     err_tot_q;
	logic            err_q;
	logic [31:0]     t_q;
	logic [9:0]      status_q;
	logic [31:0]     buckets_q [MAX_WINDOW];
	logic [31:0]     bkt_rd_q;

	logic            out_vld_q;
	logic [31:0]     out_peak_q;
	logic [31:0]     out_end_q;
	logic [31:0]     out_err_tot_q;
	logic            out_err_q;

	logic [WW-1:0]   weff;
	logic [AW-1:0]   head_n;
	logic [AW-1:0]   leave_n;
	logic [31:0]     delta;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [31:0]     mem_wd;
	logic [AW-1:0]   mem_ra;
	logic            err_n;
	logic            out_load;

	always_comb begin
		if (win_q == 13'd0) begin
			weff = WW'(1);
		end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
			weff = WW'(MAX_WINDOW);
		end else begin
			weff = WW'(win_q);
		end
	end

	assign head_n = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		if (WW'(head_n) >= weff) begin
			leave_n = AW'(WW'(head_n) - weff);
		end else begin
			leave_n = AW'(WW'(head_n) + WW'(MAX_WINDOW) - weff);
		end
	end

	assign delta    = t_q - last_q;
	assign err_n    = (status_q >= ERR_LO) && (status_q < ERR_HI);
	assign out_load = (state_q == ST_OUT) && (!out_vld_q || rsp.ready);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = head_q;
		mem_wd = '0;
		mem_ra = head_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			ST_ADV_RD: begin
				mem_ra = leave_n;
			end
			ST_ADV_WR: begin
				mem_we = 1'b1;
				mem_wa = leave_q;
			end
			ST_HEAD_WR: begin
				mem_we = 1'b1;
				mem_wd = sat_inc(bkt_rd_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			buckets_q[mem_wa] <= mem_wd;
		end
		bkt_rd_q <= buckets_q[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			t_q      <= req.event_time;
			status_q <= req.status_code;
		end
		if (state_q == ST_ADV_RD) begin
			leave_q <= leave_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			win_q      <= 13'd60;
			clr_q      <= '0;
			head_q     <= '0;
			steps_q    <= '0;
			sum_q      <= '0;
			last_q     <= '0;
			seen_q     <= 1'b0;
			best_q     <= '0;
			best_end_q <= '0;
			err_tot_q  <= '0;
			err_q      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				win_q   <= cfg_wdata;
				head_q  <= '0;
				sum_q   <= '0;
				clr_q   <= '0;
				state_q <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == AW'(MAX_WINDOW - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (req.valid) begin
							state_q <= ST_PREP;
						end
					end
					ST_PREP: begin
						if (!seen_q) begin
							seen_q     <= 1'b1;
							last_q     <= t_q;
							best_end_q <= t_q;
							state_q    <= ST_HEAD_RD;
						end else if (t_q > last_q) begin
							if (sum_q > best_q) begin
								best_q     <= sum_q;
								best_end_q <= last_q;
							end
							steps_q <= (delta < 32'(weff)) ? WW'(delta) : weff;
							last_q  <= t_q;
							state_q <= ST_ADV_RD;
						end else begin
							state_q <= ST_HEAD_RD;
						end
					end
					ST_ADV_RD: begin
						head_q  <= head_n;
						state_q <= ST_ADV_WR;
					end
					ST_ADV_WR: begin
						sum_q   <= (bkt_rd_q > sum_q) ? '0 : sum_q - bkt_rd_q;
						steps_q <= steps_q - WW'(1);
						state_q <= (steps_q == WW'(1)) ? ST_HEAD_RD : ST_ADV_RD;
					end
					ST_HEAD_RD: begin
						state_q <= ST_HEAD_WR;
					end
					ST_HEAD_WR: begin
						sum_q <= sat_inc(sum_q);
						err_q <= err_n;
						if (err_n) begin
							err_tot_q <= sat_inc(err_tot_q);
						end
						state_q <= ST_OUT;
					end
					ST_OUT: begin
						if (out_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_peak_q    <= (sum_q > best_q) ? sum_q : best_q;
			out_end_q     <= (sum_q > best_q) ? last_q : best_end_q;
			out_err_tot_q <= err_tot_q;
			out_err_q     <= err_q;
		end
	end

	assign req.ready              = (state_q == ST_IDLE);
	assign rsp.valid              = out_vld_q;
	assign rsp.peak_count         = out_peak_q;
	assign rsp.peak_window_end    = out_end_q;
	assign rsp.server_error_total = out_err_tot_q;
	assign rsp.is_server_error    = out_err_q;

	a_steps_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADV_WR |-> steps_q != '0)
		else $error("retire step with empty step count");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < 32'(MAX_WINDOW))
		else $error("ring head out of range");

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !cfg_we) |=> state_q == ST_PREP)
		else $error("accepted request not started");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("request taken during clearing pass");

endmodule

// File: dv/sliding_window_peak_rate_check.sv
`timescale 1ns / 1ps

module sliding_window_peak_rate_check #(
	parameter int MAX_WINDOW = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	swpr_req_if         req_mon,
	swpr_rsp_if         rsp_mon,
	output int          errors,
	output int          pending,
	output int          checked
);
	import swpr_pkg::SAT32;

	typedef struct packed {
		logic [31:0] peak_count;
		logic [31:0] peak_window_end;
		logic [31:0] server_error_total;
		logic        is_server_error;
	} peak_report_t;

	logic [31:0]  per_second [MAX_WINDOW];
	int unsigned  newest;
	logic [31:0]  in_window;
	logic [31:0]  latest_s;
	logic         started;
	logic [31:0]  top_count;
	logic [31:0]  top_end;
	logic [31:0]  fivexx_total;
	logic [12:0]  span_reg;
	peak_report_t awaited [$];
	int           fault_count;
	int           open_reports;
	int           report_count;

	assign errors  = fault_count;
	assign pending = open_reports;
	assign checked = report_count;

	task automatic clear_seconds();
		for (int i = 0; i < MAX_WINDOW; i++)
			per_second[i] = '0;
		newest    = 0;
		in_window = '0;
	endtask

	task automatic reset_model();
		span_reg     = 13'd60;
		clear_seconds();
		latest_s     = '0;
		started      = 1'b0;
		top_count    = '0;
		top_end      = '0;
		fivexx_total = '0;
		awaited.delete();
		open_reports = 0;
		fault_count  = 0;
		report_count = 0;
	endtask

	task automatic predict_request(input logic [31:0] t, input logic [9:0] code);
		int unsigned  span;
		int unsigned  steps;
		int unsigned  leaving;
		logic [31:0]  gap;
		logic         is_5xx;
		peak_report_t r;
		span = (span_reg == 0) ? 1 : (span_reg > MAX_WINDOW) ? MAX_WINDOW : span_reg;
		if (!started) begin
			started  = 1'b1;
			latest_s = t;
			top_end  = t;
		end
		if (t > latest_s) begin
			if (in_window > top_count) begin
				top_count = in_window;
				top_end   = latest_s;
			end
			gap   = t - latest_s;
			steps = (gap < span) ? gap : span;
			for (int k = 0; k < steps; k++) begin
				newest  = (newest + 1) % MAX_WINDOW;
				leaving = (newest + MAX_WINDOW - span) % MAX_WINDOW;
				if (per_second[leaving] > in_window)
					in_window = '0;
				else
					in_window = in_window - per_second[leaving];
				per_second[leaving] = '0;
			end
			latest_s = t;
		end
		if (per_second[newest] != SAT32)
			per_second[newest] = per_second[newest] + 32'd1;
		if (in_window != SAT32)
			in_window = in_window + 32'd1;
		is_5xx = (code / 10'd100) == 10'd5;
		if (is_5xx && fivexx_total != SAT32)
			fivexx_total = fivexx_total + 32'd1;
		r.peak_count         = (in_window > top_count) ? in_window : top_count;
		r.peak_window_end    = (in_window > top_count) ? latest_s : top_end;
		r.server_error_total = fivexx_total;
		r.is_server_error    = is_5xx;
		awaited.push_back(r);
		open_reports++;
	endtask

	task automatic compare_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	task automatic check_report();
		peak_report_t r;
		if (awaited.size() == 0) begin
			fault_count++;
			$display("%0t: unexpected result, expected none, actual peak %0d end %0d",
				$time, rsp_mon.peak_count, rsp_mon.peak_window_end);
		end else begin
			r = awaited.pop_front();
			open_reports--;
			report_count++;
			compare_field("peak_count", r.peak_count, rsp_mon.peak_count);
			compare_field("peak_window_end", r.peak_window_end, rsp_mon.peak_window_end);
			compare_field("server_error_total", r.server_error_total,
				rsp_mon.server_error_total);
			compare_field("is_server_error", {31'd0, r.is_server_error},
				{31'd0, rsp_mon.is_server_error});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg_we) begin
				span_reg = cfg_wdata;
				clear_seconds();
			end
			if (req_mon.valid && req_mon.ready)
				predict_request(req_mon.event_time, req_mon.status_code);
			if (rsp_mon.valid && rsp_mon.ready)
				check_report();
		end
	end

endmodule

// File: dv/sliding_window_peak_rate_core_test.sv
`timescale 1ns / 1ps

module sliding_window_peak_rate_core_test;
	localparam int MAX_WINDOW   = 4096;
	localparam int PHASES       = 12;
	localparam int OPENING      = 20;
	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int HOLD_CYCLES  = 300;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [12:0] cfg_wdata  = '0;
	logic        idle_sides = 1'b1;
	int          errors;
	int          pending;
	int          checked;
	int          cycle_count = 0;
	int          sent_count  = 0;
	int          write_count = 0;
	bit          held_once   = 1'b0;

	logic [31:0] opening_times [OPENING] = '{
		32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd2, 32'd2, 32'd5, 32'd4, 32'd64,
		32'd124, 32'd124, 32'd125, 32'd126, 32'd185, 32'd186, 32'd186,
		32'd10000, 32'd10059, 32'd10059};
	logic [9:0] opening_codes [OPENING] = '{
		10'd200, 10'd500, 10'd599, 10'd499, 10'd600, 10'd0, 10'd999, 10'd503,
		10'd200, 10'd404, 10'd500, 10'd301, 10'd200, 10'd550, 10'd200, 10'd500,
		10'd200, 10'd418, 10'd200, 10'd599};
	logic [12:0] span_plan [PHASES] = '{
		13'd1, 13'd0, 13'd3, 13'd8191, 13'd17, 13'd2,
		13'd4096, 13'd60, 13'd255, 13'd5, 13'd4097, 13'd31};

	swpr_req_if req_if();
	swpr_rsp_if rsp_if();

	sliding_window_peak_rate_core #(
		.MAX_WINDOW(MAX_WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	sliding_window_peak_rate_check #(
		.MAX_WINDOW(MAX_WINDOW)
	) peak_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_mon  (req_if),
		.rsp_mon  (rsp_if),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold so the core backs up
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_once && checked >= 400) begin
				held_once    = 1'b1;
				rsp_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_if.ready = !(idle_sides && $urandom_range(99) < 31);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_request(input logic [31:0] t, input logic [9:0] code);
		while (idle_sides && $urandom_range(99) < 31) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid       = 1'b1;
		req_if.event_time  = t;
		req_if.status_code = code;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic write_window(input logic [12:0] value);
		req_if.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		write_count++;
	endtask

	function automatic logic [9:0] pick_status();
		if ($urandom_range(99) < 30)
			return 10'($urandom_range(599, 500));
		return 10'($urandom_range(999));
	endfunction

	function automatic logic [31:0] pick_step(input int unsigned span);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 32'd0;
		if (roll < 80)
			return $urandom_range(3, 1);
		if (span > 512)
			return $urandom_range(40, 4);
		if (roll < 88)
			return span - 1 + $urandom_range(2);
		if (roll < 92)
			return $urandom_range(1 << 20);
		return $urandom_range(2 * span + 5, 4);
	endfunction

	initial begin
		logic [31:0] now_s;
		logic [31:0] step;
		int unsigned span;
		int unsigned count;
		req_if.valid       = 1'b0;
		req_if.event_time  = '0;
		req_if.status_code = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default window: first event, same second, earlier second, exact and
		// over-window jumps, 5xx class edges
		for (int i = 0; i < OPENING; i++)
			push_request(opening_times[i], opening_codes[i]);
		now_s = opening_times[OPENING - 1];

		for (int p = 0; p < PHASES; p++) begin
			write_window(span_plan[p]);
			span = (span_plan[p] == 0) ? 1 :
				(span_plan[p] > MAX_WINDOW) ? MAX_WINDOW : span_plan[p];
			count      = (span > 512) ? 30 : 95;
			idle_sides = (p != 5);
			if (p == PHASES - 1)
				now_s = 32'hFFFF_F000;
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(99) < 5) begin
					push_request($urandom_range(now_s), pick_status());
				end else begin
					step = (span > 512 && i == count / 2) ? span : pick_step(span);
					now_s = (now_s > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : now_s + step;
					if (p == PHASES - 1 && i == count - 1)
						now_s = 32'hFFFF_FFFF;
					push_request(now_s, pick_status());
				end
			end
		end
		req_if.valid = 1'b0;
		idle_sides   = 1'b1;

		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);

		$display("Run covered %0d requests and %0d checked results over %0d window writes",
			sent_count, checked, write_count);
		$display("Windows included 0, 1, 4096 and 8191; timestamps reached 0xFFFFFFFF");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
